// ===== rtl/csmv_pkg.sv =====
// ----------------------------------------------------------------------------
// csmv_pkg
// Shared types, constants and arithmetic helpers for the COO sparse
// matrix-vector accumulate engine.
// ----------------------------------------------------------------------------
package csmv_pkg;

   // Number of elements in each vector store.
   localparam int VEC_DEPTH = 1024;
   localparam int ADDR_W    = $clog2(VEC_DEPTH);

   // Element address into one of the vector stores.
   typedef logic [ADDR_W-1:0] addr_type;

   // Request codes.
   typedef enum logic [2:0] {
      ACT_LOAD_X    = 3'd0,
      ACT_LOAD_W    = 3'd1,
      ACT_LOAD_ACC  = 3'd2,
      ACT_NONZERO   = 3'd3,
      ACT_READ_ACC  = 3'd4,
      ACT_READ_CLR  = 3'd5
   } action_type;

   // Step controls from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic mul_a;   // form value*x and value*w
      logic sat;     // new accumulator and saturated weight product
      logic mul_b;   // form t*x
      logic fin;     // add into the bilinear total
      logic clear;   // clear the bilinear total
   } arith_ctl_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

// ===== rtl/coo_sparse_matvec_accumulate.sv =====
// ----------------------------------------------------------------------------
// coo_sparse_matvec_accumulate
// COO sparse matrix-vector engine with Q16.16 saturating accumulators.
// ----------------------------------------------------------------------------
// Software loads x, w and the starting accumulators, then issues nonzero
// triples with one-based row and column; each adds value*x[col] to acc[row]
// and value*w[row]*x[col] to the bilinear total. A request is taken when
// start is high and busy is low, and busy stays high until its result is
// shown. Every request gives exactly one result, on rsp_strobe for one cycle;
// the receiver cannot stall. Loads, reads, read-clear of the total and
// rejected requests pass through EXEC to the registered result; a valid
// nonzero passes through EXEC, SAT, MULB and TOTAL after the memory read,
// for two registered multiply steps and the accumulator write-back. The
// next request may be issued in the cycle the result is shown. The vectors
// live in two RAMs (x alone, w and acc side by side per row); they hold
// nothing defined after reset until loaded. There is no clearing pass.
// ----------------------------------------------------------------------------
module coo_sparse_matvec_accumulate (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [9:0]         req_index,
   input  logic [10:0]        req_row,
   input  logic [10:0]        req_col,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_data,
   output logic               rsp_error
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SAT,
      ST_MULB,
      ST_TOTAL
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]         action_ff;
   logic [9:0]         index_ff;
   logic [10:0]        row_ff;
   logic [10:0]        col_ff;
   logic signed [31:0] value_ff;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic signed [31:0] rsp_data_ff, rsp_data_in;
   logic               rsp_error_ff, rsp_error_in;

   logic                    accept;
   logic                    idx_ok;
   logic                    nz_ok;
   csmv_pkg::arith_ctl_type ctl;

   logic                    x_wr_en;
   csmv_pkg::addr_type      x_rd_addr;
   logic [31:0]             x_rd_data;
   logic [1:0]              row_wr_en;
   csmv_pkg::addr_type      row_wr_addr;
   logic [63:0]             row_wr_data;
   logic [31:0]             row_wr_acc;
   csmv_pkg::addr_type      row_rd_addr;
   logic [63:0]             row_rd_data;

   logic signed [31:0] acc_new;
   logic signed [31:0] total;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Range checks on the captured request.
   assign idx_ok = (32'(index_ff) < csmv_pkg::VEC_DEPTH);
   assign nz_ok  = (row_ff != '0) && (col_ff != '0) &&
                   (32'(row_ff) <= csmv_pkg::VEC_DEPTH) &&
                   (32'(col_ff) <= csmv_pkg::VEC_DEPTH);

   // Read addresses come straight from the request so data is ready in EXEC.
   assign x_rd_addr   = csmv_pkg::addr_type'(req_col - 11'd1);
   assign row_rd_addr = (req_action == csmv_pkg::ACT_NONZERO) ?
                        csmv_pkg::addr_type'(req_row - 11'd1) :
                        csmv_pkg::addr_type'(req_index);

   // Row RAM: upper lane holds w, lower lane holds the accumulator.
   assign row_wr_data = {value_ff, row_wr_acc};

   // Sequencer next-state and response logic.
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      rsp_error_in  = 1'b0;
      ctl           = '0;
      x_wr_en       = 1'b0;
      row_wr_en     = 2'b00;
      row_wr_addr   = csmv_pkg::addr_type'(index_ff);
      row_wr_acc    = value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            case (action_ff)
               csmv_pkg::ACT_LOAD_X: begin
                  if (idx_ok) x_wr_en = 1'b1;
                  else rsp_error_in = 1'b1;
               end
               csmv_pkg::ACT_LOAD_W: begin
                  if (idx_ok) row_wr_en = 2'b10;
                  else rsp_error_in = 1'b1;
               end
               csmv_pkg::ACT_LOAD_ACC: begin
                  if (idx_ok) row_wr_en = 2'b01;
                  else rsp_error_in = 1'b1;
               end
               csmv_pkg::ACT_NONZERO: begin
                  if (nz_ok) begin
                     ctl.mul_a     = 1'b1;
                     state_in      = ST_SAT;
                     rsp_strobe_in = 1'b0;
                  end else begin
                     rsp_error_in = 1'b1;
                  end
               end
               csmv_pkg::ACT_READ_ACC: begin
                  if (idx_ok) rsp_data_in = row_rd_data[31:0];
                  else rsp_error_in = 1'b1;
               end
               csmv_pkg::ACT_READ_CLR: begin
                  rsp_data_in = total;
                  ctl.clear   = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_SAT: begin
            ctl.sat  = 1'b1;
            state_in = ST_MULB;
         end
         ST_MULB: begin
            // Write the new accumulator back while t*x is formed.
            ctl.mul_b   = 1'b1;
            row_wr_en   = 2'b01;
            row_wr_addr = csmv_pkg::addr_type'(row_ff - 11'd1);
            row_wr_acc  = acc_new;
            state_in    = ST_TOTAL;
         end
         ST_TOTAL: begin
            ctl.fin       = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_data_in   = acc_new;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, captured request and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff  <= rsp_data_in;
      rsp_error_ff <= rsp_error_in;
      if (accept) begin
         action_ff <= req_action;
         index_ff  <= req_index;
         row_ff    <= req_row;
         col_ff    <= req_col;
         value_ff  <= req_value;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_error  = rsp_error_ff;

   // Column vector store.
   csmv_ram #(
      .WIDTH (32),
      .DEPTH (csmv_pkg::VEC_DEPTH),
      .LANES (1)
   ) u_x_ram (
      .clock   (clock),
      .wr_en   (x_wr_en),
      .wr_addr (csmv_pkg::addr_type'(index_ff)),
      .wr_data (value_ff),
      .rd_en   (accept),
      .rd_addr (x_rd_addr),
      .rd_data (x_rd_data)
   );

   // Row weight and accumulator store.
   csmv_ram #(
      .WIDTH (64),
      .DEPTH (csmv_pkg::VEC_DEPTH),
      .LANES (2)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (accept),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   csmv_arith u_arith (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .value    (value_ff),
      .x_elem   (x_rd_data),
      .w_elem   (row_rd_data[63:32]),
      .acc_elem (row_rd_data[31:0]),
      .acc_new  (acc_new),
      .total    (total)
   );

endmodule

// ===== rtl/csmv_ram.sv =====
// ----------------------------------------------------------------------------
// csmv_ram
// Simple dual-port synchronous RAM with lane write enables and a registered
// read port.
// ----------------------------------------------------------------------------
module csmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int LANES = 1
) (
   input  logic                     clock,
   input  logic [LANES-1:0]         wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   localparam int LANE_W = WIDTH / LANES;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write each enabled lane.
   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (wr_en[i]) begin
            mem[wr_addr][i*LANE_W +: LANE_W] <= wr_data[i*LANE_W +: LANE_W];
         end
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/csmv_arith.sv =====
// ----------------------------------------------------------------------------
// csmv_arith
// Multiply and saturate datapath for one nonzero, plus the bilinear total.
// Each product is registered before it is used again.
// ----------------------------------------------------------------------------
module csmv_arith (
   input  logic                     clock,
   input  logic                     reset,
   input  csmv_pkg::arith_ctl_type  ctl,
   input  logic signed [31:0]       value,
   input  logic signed [31:0]       x_elem,
   input  logic signed [31:0]       w_elem,
   input  logic signed [31:0]       acc_elem,
   output logic signed [31:0]       acc_new,
   output logic signed [31:0]       total
);

   logic signed [63:0] pax_ff;
   logic signed [63:0] pvw_ff;
   logic signed [31:0] acc_new_ff;
   logic signed [31:0] t_ff;
   logic signed [63:0] ptx_ff;
   logic signed [31:0] total_ff;

   logic signed [63:0] pax_in;
   logic signed [63:0] pvw_in;
   logic signed [63:0] ptx_in;
   logic signed [63:0] pax_sh;
   logic signed [63:0] pvw_sh;
   logic signed [63:0] ptx_sh;
   logic signed [63:0] acc_ext;
   logic signed [63:0] total_ext;
   logic signed [31:0] total_in;

   // Full-precision products.
   assign pax_in = value * x_elem;
   assign pvw_in = value * w_elem;
   assign ptx_in = t_ff * x_elem;

   // Q16.16 rescale: arithmetic shift, which floors.
   assign pax_sh = pax_ff >>> 16;
   assign pvw_sh = pvw_ff >>> 16;
   assign ptx_sh = ptx_ff >>> 16;

   assign acc_ext   = {{32{acc_elem[31]}}, acc_elem};
   assign total_ext = {{32{total_ff[31]}}, total_ff};
   assign total_in  = csmv_pkg::sat32(total_ext + ptx_sh);

   // Product and saturation stages.
   always_ff @(posedge clock) begin
      if (ctl.mul_a) begin
         pax_ff <= pax_in;
         pvw_ff <= pvw_in;
      end
      if (ctl.sat) begin
         acc_new_ff <= csmv_pkg::sat32(acc_ext + pax_sh);
         t_ff       <= csmv_pkg::sat32(pvw_sh);
      end
      if (ctl.mul_b) begin
         ptx_ff <= ptx_in;
      end
   end

   // Bilinear total.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (ctl.clear) begin
         total_ff <= '0;
      end else if (ctl.fin) begin
         total_ff <= total_in;
      end
   end

   assign acc_new = acc_new_ff;
   assign total   = total_ff;

endmodule

// ===== rtl/csmv_checker.sv =====
// ----------------------------------------------------------------------------
// csmv_checker
// Port-level checks on the request/response sequencing of the engine.
// ----------------------------------------------------------------------------
module csmv_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_data,
   input logic               rsp_error
);

   // A transfer always makes the engine busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after a request transfer");

   // The engine goes idle exactly when it shows a result.
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy dropped without a result");

   // A result is never shown while a request is still in flight.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // One result per request: results never come in back-to-back cycles.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   // A rejected request returns zero data.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error) |-> (rsp_data == 32'sd0))
      else $error("error result carries nonzero data");

endmodule

bind coo_sparse_matvec_accumulate csmv_checker u_csmv_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data),
   .rsp_error  (rsp_error)
);
